[hw/rtl/ucc_pkg.sv]
// ----------------------------------------------------------------------------
// ucc_pkg: shared types and constants of the UTF-8 text console cursor
// Action and command records, codes and fixed widths used by front and back.
// ----------------------------------------------------------------------------
package ucc_pkg;

  // Fixed field widths
  localparam int unsigned CoordW = 12;
  localparam int unsigned CpW    = 21;
  localparam int unsigned GlyphW = 16;

  // Configuration register indexes
  localparam logic RegScreenWidth  = 1'b0;
  localparam logic RegScreenHeight = 1'b1;

  // Command kinds on the result channel
  localparam logic CmdDraw   = 1'b0;
  localparam logic CmdScroll = 1'b1;

  // U+FFFD, shown for every broken sequence
  localparam logic [CpW-1:0] ReplacementCp = 21'h00FFFD;

  // Work items between front and back
  typedef enum logic {
    ACT_SHOW,
    ACT_BREAK
  } act_kind_e;

  typedef struct packed {
    act_kind_e        kind;
    logic [CpW-1:0]   cp;
    logic             last;   // final action caused by its text byte
  } act_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [GlyphW-1:0] glyph_index;
    logic              wide_glyph;
    logic [CoordW-1:0] cursor_column;
    logic [CoordW-1:0] cursor_row;
    logic              last_of_run;
  } cmd_t;

endpackage

[hw/rtl/ucc_front.sv]
// ----------------------------------------------------------------------------
// ucc_front: UTF-8 decoder front end
// Takes text bytes, tracks the pending sequence and pushes show and
// line-break actions, one per cycle while the queue is not full, into the action queue.
// ----------------------------------------------------------------------------
module ucc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  output logic              push_o,
  output ucc_pkg::act_t     push_act_o,
  input  logic              full_i
);

  // Decoder state
  logic [1:0]                 rem_q, rem_d;
  logic [1:0]                 seen_q, seen_d;
  logic [ucc_pkg::CpW-1:0]    acc_q, acc_d;
  // Replay of the current byte
  logic [1:0]                 rep_q, rep_d;
  logic                       lead_vld_q, lead_vld_d;
  ucc_pkg::act_t              lead_q, lead_d;

  logic busy;
  logic accept;
  logic is_cont;
  logic [ucc_pkg::CpW-1:0] acc_next;

  assign busy       = (rep_q != 2'd0) || lead_vld_q;
  assign in_ready_o = !busy;
  assign accept     = in_valid_i && !busy;
  assign is_cont    = (text_byte_i[7:6] == 2'b10);
  assign acc_next   = {acc_q[ucc_pkg::CpW-7:0], text_byte_i[5:0]};

  // Decode one accepted byte into replay count, lead action and new state
  always_comb begin
    rem_d      = rem_q;
    seen_d     = seen_q;
    acc_d      = acc_q;
    rep_d      = rep_q;
    lead_vld_d = lead_vld_q;
    lead_d     = lead_q;

    if (accept) begin
      rep_d       = 2'd0;
      lead_vld_d  = 1'b0;
      lead_d.kind = ucc_pkg::ACT_SHOW;
      lead_d.cp   = ucc_pkg::ReplacementCp;
      lead_d.last = 1'b1;

      if ((rem_q != 2'd0) && is_cont) begin
        // good continuation
        acc_d  = acc_next;
        seen_d = seen_q + 2'd1;
        rem_d  = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          seen_d     = 2'd0;
          acc_d      = '0;
          lead_vld_d = 1'b1;
          lead_d.cp  = acc_next;
        end
      end else begin
        if (rem_q != 2'd0) begin
          // broken sequence: one U+FFFD for the lead and each continuation
          rep_d  = seen_q + 2'd1;
          rem_d  = 2'd0;
          seen_d = 2'd0;
          acc_d  = '0;
        end
        // byte taken as a lead
        if (text_byte_i == 8'h00) begin
          lead_vld_d = 1'b0;
        end else if (text_byte_i == 8'h0A) begin
          lead_vld_d  = 1'b1;
          lead_d.kind = ucc_pkg::ACT_BREAK;
        end else if (text_byte_i < 8'h80) begin
          lead_vld_d = 1'b1;
          lead_d.cp  = ucc_pkg::CpW'(text_byte_i);
        end else if (text_byte_i inside {[8'hC0:8'hDF]}) begin
          rem_d  = 2'd1;
          seen_d = 2'd0;
          acc_d  = ucc_pkg::CpW'(text_byte_i[4:0]);
        end else if (text_byte_i inside {[8'hE0:8'hEF]}) begin
          rem_d  = 2'd2;
          seen_d = 2'd0;
          acc_d  = ucc_pkg::CpW'(text_byte_i[3:0]);
        end else if (text_byte_i inside {[8'hF0:8'hF7]}) begin
          rem_d  = 2'd3;
          seen_d = 2'd0;
          acc_d  = ucc_pkg::CpW'(text_byte_i[2:0]);
        end else begin
          lead_vld_d = 1'b1;
        end
      end
    end else if (busy && !full_i) begin
      // one action leaves per cycle while the queue has room
      if (rep_q != 2'd0) begin
        rep_d = rep_q - 2'd1;
      end else begin
        lead_vld_d = 1'b0;
      end
    end
  end

  // Action offered to the queue: replacements first, then the lead action
  always_comb begin
    push_o = busy && !full_i;
    if (rep_q != 2'd0) begin
      push_act_o.kind = ucc_pkg::ACT_SHOW;
      push_act_o.cp   = ucc_pkg::ReplacementCp;
      push_act_o.last = (rep_q == 2'd1) && !lead_vld_q;
    end else begin
      push_act_o = lead_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q      <= 2'd0;
      seen_q     <= 2'd0;
      acc_q      <= '0;
      rep_q      <= 2'd0;
      lead_vld_q <= 1'b0;
    end else begin
      rem_q      <= rem_d;
      seen_q     <= seen_d;
      acc_q      <= acc_d;
      rep_q      <= rep_d;
      lead_vld_q <= lead_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
  end

endmodule

[hw/rtl/ucc_fifo.sv]
// ----------------------------------------------------------------------------
// ucc_fifo: action queue
// Small register queue between decoder and cursor engine.
// ----------------------------------------------------------------------------
module ucc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ucc_pkg::act_t push_act_i,
  output logic          full_o,
  input  logic          pop_i,
  output ucc_pkg::act_t pop_act_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  ucc_pkg::act_t       mem_q [DEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_act_o = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_act_i;
    end
  end

endmodule

[hw/rtl/ucc_back.sv]
// ----------------------------------------------------------------------------
// ucc_back: cursor engine
// Carries out show and line-break actions on the column and row counters
// and produces draw and scroll commands through a hold and output register.
// ----------------------------------------------------------------------------
module ucc_back #(
  parameter int unsigned GLYPH_ROWS   = 16,
  parameter int unsigned NARROW_WIDTH = 8,
  parameter int unsigned DOUBLE_WIDTH = 16,
  parameter int unsigned GLYPH_COUNT  = 65536
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ucc_pkg::CoordW-1:0]  screen_width_i,
  input  logic [ucc_pkg::CoordW-1:0]  screen_height_i,
  input  logic                        empty_i,
  input  ucc_pkg::act_t               act_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ucc_pkg::cmd_t               cmd_o
);

  localparam int unsigned CW      = ucc_pkg::CoordW;
  localparam int unsigned CellMax = (NARROW_WIDTH > DOUBLE_WIDTH) ? NARROW_WIDTH : DOUBLE_WIDTH;
  localparam int unsigned CellW   = $clog2(CellMax + 1);
  localparam int unsigned PxW     = CW + CellW;
  localparam int unsigned NarW    = $clog2(NARROW_WIDTH + 1);
  localparam int unsigned WrapW   = CW + NarW;
  localparam int unsigned RowW    = $clog2(GLYPH_ROWS + 1);
  localparam int unsigned PyW     = CW + RowW;
  localparam logic [ucc_pkg::CpW:0]     GlyphLimit    = (ucc_pkg::CpW + 1)'(GLYPH_COUNT);
  localparam logic [ucc_pkg::GlyphW-1:0] FallbackGlyph = 16'h003F;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHOW  = 3'd1;
  localparam logic [2:0] S_WRAP  = 3'd2;
  localparam logic [2:0] S_BREAK = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0]           state_q, state_d;
  ucc_pkg::act_t        act_q, act_d;
  logic [CW-1:0]        col_q, col_d;
  logic [CW-1:0]        row_q, row_d;
  ucc_pkg::cmd_t        hold_q, hold_d;
  logic                 hold_vld_q, hold_vld_d;
  ucc_pkg::cmd_t        out_q, out_d;
  logic                 out_vld_q, out_vld_d;

  logic                 out_free, can_emit;
  logic                 emit;
  ucc_pkg::cmd_t        new_cmd;

  logic                 wide;
  logic [CellW-1:0]     cell_w;
  logic [PxW-1:0]       px;
  logic [PyW-1:0]       py;
  logic                 visible;
  logic [WrapW-1:0]     wrap_px;
  logic [CW-1:0]        row_inc;
  logic [PyW-1:0]       py_inc;
  logic                 scroll;
  logic [CW-1:0]        row_after;

  // Wide classes: CJK unified, hiragana, katakana, fullwidth forms
  function automatic logic is_wide(input logic [ucc_pkg::CpW-1:0] cp);
    is_wide = (cp inside {[21'h004E00:21'h009FFF]}) ||
              (cp inside {[21'h003040:21'h00309F]}) ||
              (cp inside {[21'h0030A0:21'h0030FF]}) ||
              (cp inside {[21'h00FF00:21'h00FFEF]});
  endfunction

  assign out_free = !out_vld_q || out_ready_i;
  assign can_emit = !hold_vld_q || out_free;

  // Cell position of the current glyph
  assign wide    = is_wide(act_q.cp);
  assign cell_w  = wide ? CellW'(DOUBLE_WIDTH) : CellW'(NARROW_WIDTH);
  assign px      = PxW'(col_q) * PxW'(cell_w);
  assign py      = PyW'(row_q) * PyW'(GLYPH_ROWS);
  assign visible = (px < PxW'(screen_width_i)) && (py < PyW'(screen_height_i));

  // Wrap test on the column after the glyph
  assign wrap_px = WrapW'(col_q) * WrapW'(NARROW_WIDTH);

  // Line break: next row, scroll when it falls below the screen
  assign row_inc   = row_q + CW'(1);
  assign py_inc    = PyW'(row_inc) * PyW'(GLYPH_ROWS);
  assign scroll    = (py_inc >= PyW'(screen_height_i));
  assign row_after = scroll ? ((row_inc == '0) ? '0 : row_q) : row_inc;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    act_d      = act_q;
    col_d      = col_q;
    row_d      = row_q;
    hold_d     = hold_q;
    hold_vld_d = hold_vld_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    pop_o      = 1'b0;
    emit       = 1'b0;
    new_cmd    = '0;

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          act_d   = act_i;
          state_d = (act_i.kind == ucc_pkg::ACT_SHOW) ? S_SHOW : S_BREAK;
        end
      end
      S_SHOW: begin
        if (!visible || can_emit) begin
          if (visible) begin
            col_d                 = col_q + CW'(1);
            emit                  = 1'b1;
            new_cmd.kind          = ucc_pkg::CmdDraw;
            new_cmd.pixel_x       = px[CW-1:0];
            new_cmd.pixel_y       = py[CW-1:0];
            new_cmd.glyph_index   = ({1'b0, act_q.cp} < GlyphLimit) ?
                                    act_q.cp[ucc_pkg::GlyphW-1:0] : FallbackGlyph;
            new_cmd.wide_glyph    = wide;
            new_cmd.cursor_column = col_q + CW'(1);
            new_cmd.cursor_row    = row_q;
          end
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        state_d = (wrap_px >= WrapW'(screen_width_i)) ? S_BREAK : S_END;
      end
      S_BREAK: begin
        if (!scroll || can_emit) begin
          col_d = '0;
          row_d = row_after;
          if (scroll) begin
            emit               = 1'b1;
            new_cmd.kind       = ucc_pkg::CmdScroll;
            new_cmd.cursor_row = row_after;
          end
          state_d = S_END;
        end
      end
      S_END: begin
        // last action of its byte: release the held command as final
        if (!act_q.last || !hold_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d             = hold_q;
          out_d.last_of_run = 1'b1;
          out_vld_d         = 1'b1;
          hold_vld_d        = 1'b0;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // New command goes to hold; the older one moves on as not final
    if (emit) begin
      if (hold_vld_q) begin
        out_d     = hold_q;
        out_vld_d = 1'b1;
      end
      hold_d     = new_cmd;
      hold_vld_d = 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign cmd_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      col_q      <= '0;
      row_q      <= '0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_q      <= row_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

endmodule

[hw/rtl/utf8_text_console_cursor.sv]
// ----------------------------------------------------------------------------
// utf8_text_console_cursor: UTF-8 text console cursor
// Decodes text bytes and drives a character cursor, giving draw and scroll
// commands for each byte.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  text in   in         in_valid_i / in_ready_o    text_byte_i
//  commands  out        out_valid_o / out_ready_i  command_kind_o .. last_of_run_o
//  config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
//  Once a byte is taken, the decoder pushes one action per cycle while the
//  queue has room (up to three replacements plus one lead action) and takes
//  no byte meanwhile. The cursor engine steps through fetch, place, wrap test
//  and finish for a glyph, adding a line break before finish when it wraps,
//  and through fetch, line break and finish for a newline action.
//  A four-entry action queue lets decoder and engine stall independently.
//  The final command of a byte is held back until the byte's last action is
//  done; output backpressure stalls the engine, and the decoder once the queue fills.
//  Reset clears the decoder, cursor and queue; screen size returns to 640x480.
// ----------------------------------------------------------------------------
module utf8_text_console_cursor #(
  parameter int unsigned GLYPH_ROWS   = 16,
  parameter int unsigned NARROW_WIDTH = 8,
  parameter int unsigned DOUBLE_WIDTH = 16,
  parameter int unsigned GLYPH_COUNT  = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  // text bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  // commands
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        command_kind_o,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [15:0] glyph_index_o,
  output logic        wide_glyph_o,
  output logic [11:0] cursor_column_o,
  output logic [11:0] cursor_row_o,
  output logic        last_of_run_o
);

  logic [ucc_pkg::CoordW-1:0] screen_width_q;
  logic [ucc_pkg::CoordW-1:0] screen_height_q;

  logic          push;
  ucc_pkg::act_t push_act;
  logic          full;
  logic          pop;
  ucc_pkg::act_t pop_act;
  logic          empty;
  ucc_pkg::cmd_t cmd;

  // Screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= 12'd640;
      screen_height_q <= 12'd480;
    end else if (cfg_we_i) begin
      if (cfg_index_i == ucc_pkg::RegScreenWidth) begin
        screen_width_q <= cfg_data_i;
      end else begin
        screen_height_q <= cfg_data_i;
      end
    end
  end

  ucc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .text_byte_i(text_byte_i),
    .push_o     (push),
    .push_act_o (push_act),
    .full_i     (full)
  );

  ucc_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_act_i(push_act),
    .full_o    (full),
    .pop_i     (pop),
    .pop_act_o (pop_act),
    .empty_o   (empty)
  );

  ucc_back #(
    .GLYPH_ROWS  (GLYPH_ROWS),
    .NARROW_WIDTH(NARROW_WIDTH),
    .DOUBLE_WIDTH(DOUBLE_WIDTH),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .screen_width_i (screen_width_q),
    .screen_height_i(screen_height_q),
    .empty_i        (empty),
    .act_i          (pop_act),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd)
  );

  assign command_kind_o  = cmd.kind;
  assign pixel_x_o       = cmd.pixel_x;
  assign pixel_y_o       = cmd.pixel_y;
  assign glyph_index_o   = cmd.glyph_index;
  assign wide_glyph_o    = cmd.wide_glyph;
  assign cursor_column_o = cmd.cursor_column;
  assign cursor_row_o    = cmd.cursor_row;
  assign last_of_run_o   = cmd.last_of_run;

endmodule

[hw/rtl/ucc_checker.sv]
// ----------------------------------------------------------------------------
// ucc_checker: port-level checks of the text console cursor
// Watches the command channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ucc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        command_kind_o,
  input logic [11:0] pixel_x_o,
  input logic [11:0] pixel_y_o,
  input logic [15:0] glyph_index_o,
  input logic        wide_glyph_o,
  input logic [11:0] cursor_column_o,
  input logic [11:0] cursor_row_o,
  input logic        last_of_run_o
);

  // A stalled command holds its kind, cursor position and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_column_o) &&
      $stable(cursor_row_o) && $stable(last_of_run_o) && $stable(command_kind_o))
    else $error("command changed while stalled");

  // Scroll commands carry no cell, no glyph and a cursor at column 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_kind_o == ucc_pkg::CmdScroll) |->
      (pixel_x_o == 12'd0) && (pixel_y_o == 12'd0) && (glyph_index_o == 16'd0) &&
      !wide_glyph_o && (cursor_column_o == 12'd0))
    else $error("scroll command with nonzero cell fields");

  // A drawn glyph always advances the cursor past column 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_kind_o == ucc_pkg::CmdDraw) |-> (cursor_column_o != 12'd0))
    else $error("draw command left cursor at column 0");

endmodule

bind utf8_text_console_cursor ucc_checker u_checker (.*);

[sim/utf8_text_console_cursor_tb.sv]
// ----------------------------------------------------------------------------
// utf8_text_console_cursor_tb: self-checking bench for the UTF-8 text console
// Feeds text bytes through a valid/ready driver, predicts every draw and
// scroll command with a cycle-free model of decoder and cursor, and checks
// each command field by field. Screen size is changed between phases while
// the block is idle; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module utf8_text_console_cursor_tb;

  localparam int unsigned RowPixels    = 16;
  localparam int unsigned NarrowPixels = 8;
  localparam int unsigned WidePixels   = 16;
  localparam int unsigned FontGlyphs   = 65536;
  localparam int unsigned MaxRun       = 8;
  localparam int unsigned SettleCycles = 60;

  localparam logic [7:0]  TextEnd       = 8'h00;
  localparam logic [7:0]  TextNewline   = 8'h0A;
  localparam logic [15:0] GlyphFallback = 16'h003F;

  localparam logic [20:0] CjkLo  = 21'h4E00;
  localparam logic [20:0] CjkHi  = 21'h9FFF;
  localparam logic [20:0] HiraLo = 21'h3040;
  localparam logic [20:0] HiraHi = 21'h309F;
  localparam logic [20:0] KataLo = 21'h30A0;
  localparam logic [20:0] KataHi = 21'h30FF;
  localparam logic [20:0] FullLo = 21'hFF00;
  localparam logic [20:0] FullHi = 21'hFFEF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = ucc_pkg::RegScreenWidth;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        command_kind_o;
  logic [11:0] pixel_x_o;
  logic [11:0] pixel_y_o;
  logic [15:0] glyph_index_o;
  logic        wide_glyph_o;
  logic [11:0] cursor_column_o;
  logic [11:0] cursor_row_o;
  logic        last_of_run_o;

  utf8_text_console_cursor #(
    .GLYPH_ROWS  (RowPixels),
    .NARROW_WIDTH(NarrowPixels),
    .DOUBLE_WIDTH(WidePixels),
    .GLYPH_COUNT (FontGlyphs)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .text_byte_i    (text_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_kind_o (command_kind_o),
    .pixel_x_o      (pixel_x_o),
    .pixel_y_o      (pixel_y_o),
    .glyph_index_o  (glyph_index_o),
    .wide_glyph_o   (wide_glyph_o),
    .cursor_column_o(cursor_column_o),
    .cursor_row_o   (cursor_row_o),
    .last_of_run_o  (last_of_run_o)
  );

  // Bench state
  logic [7:0]     text_feed[$];
  ucc_pkg::cmd_t  pending_cmds[$];
  ucc_pkg::cmd_t  run_cmds[$];
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned err_count = 0;
  logic        in_fire = 1'b0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;

  // Predicted screen size, decoder and cursor
  logic [11:0] scr_w = 12'd640;
  logic [11:0] scr_h = 12'd480;
  logic [1:0]  seq_left = '0;
  logic [1:0]  cont_seen = '0;
  logic [20:0] cp_acc = '0;
  logic [11:0] cur_col = '0;
  logic [11:0] cur_row = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("utf8_text_console_cursor_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit is_wide_cp(input logic [20:0] cp);
    return (cp >= CjkLo && cp <= CjkHi) || (cp >= HiraLo && cp <= HiraHi) ||
           (cp >= KataLo && cp <= KataHi) || (cp >= FullLo && cp <= FullHi);
  endfunction

  function automatic void add_cmd(input logic kind, input logic [11:0] px,
                                  input logic [11:0] py, input logic [15:0] glyph,
                                  input logic wide);
    ucc_pkg::cmd_t c;
    if (run_cmds.size() < MaxRun) begin
      c.kind          = kind;
      c.pixel_x       = px;
      c.pixel_y       = py;
      c.glyph_index   = glyph;
      c.wide_glyph    = wide;
      c.cursor_column = cur_col;
      c.cursor_row    = cur_row;
      c.last_of_run   = 1'b0;
      run_cmds.push_back(c);
    end
  endfunction

  // Next row; scroll when it falls below the screen
  function automatic void break_line();
    cur_col = '0;
    cur_row = cur_row + 1'b1;
    if (cur_row * RowPixels >= scr_h) begin
      if (cur_row != 0) cur_row = cur_row - 1'b1;
      add_cmd(ucc_pkg::CmdScroll, '0, '0, '0, 1'b0);
    end
  endfunction

  // Draw if on screen, then the wrap test
  function automatic void place_glyph(input logic [20:0] cp);
    bit          wide;
    int unsigned cell_w;
    int unsigned px;
    int unsigned py;
    logic [15:0] glyph;
    wide   = is_wide_cp(cp);
    cell_w = wide ? WidePixels : NarrowPixels;
    glyph  = (cp < FontGlyphs) ? cp[15:0] : GlyphFallback;
    px     = cur_col * cell_w;
    py     = cur_row * RowPixels;
    if (px < scr_w && py < scr_h) begin
      cur_col = cur_col + 1'b1;
      add_cmd(ucc_pkg::CmdDraw, px[11:0], py[11:0], glyph, wide);
    end
    if (cur_col * NarrowPixels >= scr_w) break_line();
  endfunction

  function automatic void take_lead_byte(input logic [7:0] b);
    if (b == TextEnd) begin
      // end of string: nothing to do
    end else if (b == TextNewline) begin
      break_line();
    end else if (b[7] == 1'b0) begin
      place_glyph({13'd0, b});
    end else if (b[7:5] == 3'b110) begin
      seq_left  = 2'd1;
      cont_seen = '0;
      cp_acc    = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      seq_left  = 2'd2;
      cont_seen = '0;
      cp_acc    = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      seq_left  = 2'd3;
      cont_seen = '0;
      cp_acc    = {18'd0, b[2:0]};
    end else begin
      place_glyph(ucc_pkg::ReplacementCp);
    end
  endfunction

  function automatic void decode_text_byte(input logic [7:0] b);
    int unsigned   reps;
    logic [20:0]   cp;
    ucc_pkg::cmd_t c;
    run_cmds.delete();
    if (seq_left != 0) begin
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_seen = cont_seen + 1'b1;
        seq_left  = seq_left - 1'b1;
        if (seq_left == 0) begin
          cp        = cp_acc;
          cont_seen = '0;
          cp_acc    = '0;
          place_glyph(cp);
        end
      end else begin
        // broken sequence: one replacement per byte seen, then reread the byte
        reps      = cont_seen + 1;
        seq_left  = '0;
        cont_seen = '0;
        cp_acc    = '0;
        repeat (reps) place_glyph(ucc_pkg::ReplacementCp);
        take_lead_byte(b);
      end
    end else begin
      take_lead_byte(b);
    end
    foreach (run_cmds[i]) begin
      c = run_cmds[i];
      c.last_of_run = (i == run_cmds.size() - 1);
      pending_cmds.push_back(c);
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic check_command();
    ucc_pkg::cmd_t want;
    if (pending_cmds.size() == 0) begin
      $display("%0t: command expected none got kind %0h x %0h y %0h glyph %0h",
               $time, command_kind_o, pixel_x_o, pixel_y_o, glyph_index_o);
      err_count++;
    end else begin
      want = pending_cmds.pop_front();
      check_field("command_kind", 16'(want.kind), 16'(command_kind_o));
      check_field("pixel_x", 16'(want.pixel_x), 16'(pixel_x_o));
      check_field("pixel_y", 16'(want.pixel_y), 16'(pixel_y_o));
      check_field("glyph_index", want.glyph_index, glyph_index_o);
      check_field("wide_glyph", 16'(want.wide_glyph), 16'(wide_glyph_o));
      check_field("cursor_column", 16'(want.cursor_column), 16'(cursor_column_o));
      check_field("cursor_row", 16'(want.cursor_row), 16'(cursor_row_o));
      check_field("last_of_run", 16'(want.last_of_run), 16'(last_of_run_o));
    end
  endtask

  // Monitor: both handshakes at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) check_command();
      if (in_valid_i && in_ready_o) begin
        decode_text_byte(text_byte_i);
        bytes_taken++;
      end
    end
  end

  // ---------------------------------------------------------------- driving
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Text byte driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_fire) begin
      // item still waiting: hold it
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (text_feed.size() > 0) begin
      in_valid_i  <= 1'b1;
      text_byte_i <= text_feed.pop_front();
      gap_left    = tx_gaps_on ? pick_gap() : 0;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Command receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = 150;
      out_ready_i    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!rx_stalls_on) begin
      out_ready_i <= 1'b1;
    end else if (r < 2) begin
      hold_left   = $urandom_range(20, 50);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (r >= 32);
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push_text(input logic [7:0] b);
    text_feed.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_list(input logic [7:0] list[$]);
    foreach (list[i]) push_text(list[i]);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ucc_pkg::RegScreenWidth) scr_w = val;
    else scr_h = val;
  endtask

  task automatic set_screen(input logic [11:0] w, input logic [11:0] h);
    write_reg(ucc_pkg::RegScreenWidth, w);
    write_reg(ucc_pkg::RegScreenHeight, h);
  endtask

  task automatic set_idling(input bit tx, input bit rx);
    @(posedge clk_i);
    tx_gaps_on   = tx;
    rx_stalls_on = rx;
  endtask

  // Wait until every byte is taken and every command seen, then let the
  // engine finish any action that gives no command
  task automatic wait_idle();
    @(negedge clk_i);
    while (bytes_taken != bytes_queued || pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] lead_of_len(input int unsigned len);
    if (len == 1) return 8'hC0 | 8'($urandom_range(0, 31));
    if (len == 2) return 8'hE0 | 8'($urandom_range(0, 15));
    return 8'hF0 | 8'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed text with random content, some broken sequences and noise
  task automatic feed_random_text(input int unsigned count);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    int unsigned good;
    logic [20:0] cp;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        push_text(8'($urandom_range(1, 127)));
      end else if (r < 48) begin
        push_text(TextNewline);
      end else if (r < 60) begin
        push_text(lead_of_len(1));
        push_text(cont_byte());
      end else if (r < 75) begin
        case ($urandom_range(0, 4))
          0: cp = 21'($urandom_range(CjkLo, CjkHi));
          1: cp = 21'($urandom_range(HiraLo, KataHi));
          2: cp = 21'($urandom_range(FullLo - 16, FullHi + 16));
          default: cp = 21'($urandom_range(0, 16'hFFFF));
        endcase
        push_text({4'hE, cp[15:12]});
        push_text({2'b10, cp[11:6]});
        push_text({2'b10, cp[5:0]});
      end else if (r < 83) begin
        push_text(lead_of_len(3));
        repeat (3) push_text(cont_byte());
      end else if (r < 90) begin
        len  = $urandom_range(1, 3);
        good = $urandom_range(0, len - 1);
        push_text(lead_of_len(len));
        repeat (good) push_text(cont_byte());
        case ($urandom_range(0, 4))
          0: push_text(8'($urandom_range(1, 127)));
          1: push_text(TextNewline);
          2: push_text(TextEnd);
          3: push_text(8'($urandom_range(8'hC0, 8'hF7)));
          default: push_text(8'($urandom_range(8'hF8, 8'hFF)));
        endcase
      end else if (r < 95) begin
        if ($urandom_range(0, 1)) push_text(8'($urandom_range(8'h80, 8'hBF)));
        else push_text(8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        if ($urandom_range(0, 1)) push_text(TextEnd);
        else push_text(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [11:0] w;
    logic [11:0] h;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text at the default screen size
    set_screen(12'd640, 12'd480);
    set_idling(1'b1, 1'b1);
    directed = '{8'h41, 8'h7F, TextNewline,
                 8'hC0, 8'h8A,                // overlong form of code point 10
                 8'hE4, 8'hB8, 8'h80,         // first CJK ideograph, wide
                 8'hF4, 8'h8F, 8'hBF, 8'hBF,  // beyond the font
                 8'h80, 8'hFF, 8'hF8,         // invalid leads
                 8'hE3, 8'h81, TextNewline,   // newline breaks a sequence
                 8'hF0, 8'h90, 8'h80, TextEnd,// end byte with a sequence pending
                 8'hC3, 8'hC3, 8'hA9};        // new lead breaks a sequence
    push_list(directed);
    wait_idle();

    // One-cell screen: every glyph wraps and scrolls, a broken 4-byte
    // sequence gives the longest run of commands
    set_screen(12'd8, 12'd16);
    directed = '{8'hF0, 8'h90, 8'h80, 8'h41};
    push_list(directed);
    feed_random_text(40);
    wait_idle();

    // Zero-size screen
    set_screen(12'd0, 12'd0);
    set_idling(1'b1, 1'b0);
    feed_random_text(30);
    wait_idle();

    // Largest screen, no idling, one long output hold-off
    set_screen(12'd4095, 12'd4095);
    set_idling(1'b0, 1'b0);
    long_hold_req = 1'b1;
    feed_random_text(60);
    wait_idle();

    // Random screen sizes, mostly small so wrap and scroll come often
    repeat (6) begin
      w = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, 160));
      h = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                      : 12'($urandom_range(0, 128));
      set_screen(w, h);
      set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      feed_random_text(52);
      wait_idle();
    end

    if (err_count == 0) begin
      $display("utf8_text_console_cursor_tb: clean");
    end else begin
      $display("utf8_text_console_cursor_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ucc_pkg.sv
hw/rtl/ucc_front.sv
hw/rtl/ucc_fifo.sv
hw/rtl/ucc_back.sv
hw/rtl/utf8_text_console_cursor.sv
hw/rtl/ucc_checker.sv
sim/utf8_text_console_cursor_tb.sv
